@@ sv/assert_macros.svh @@
// assertion macros shared by the filter modules
// needs signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define RMF_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RMF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/rmf_pkg.sv @@
// types, constants and helpers of the running median filter
// used by every module of the filter, depends on nothing
package rmf_pkg;

   localparam int MAX_HALF    = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int DEPTH       = 2 * MAX_HALF + 1;
   localparam int HALF_BITS   = 6;
   localparam int AGE_BITS    = $clog2(DEPTH + 1);
   localparam int CNT_BITS    = AGE_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          is_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS:0] median_twice;
      logic                        final_result;
   } rsp_type;

   // one queued step for the back end
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          wr;
      logic                          emit;
      logic [AGE_BITS-1:0]           left;
      logic                          fin;
   } job_type;

   // store index of the sample at a given age (0 = newest)
   function automatic logic [AGE_BITS-1:0] age_to_idx(
      input logic [AGE_BITS-1:0] wptr,
      input logic [AGE_BITS-1:0] age
   );
      logic signed [AGE_BITS+1:0] t;
      t = $signed({2'b00, wptr}) - $signed((AGE_BITS+2)'(1)) - $signed({2'b00, age});
      if (t < 0) begin
         t = t + $signed((AGE_BITS+2)'(DEPTH));
      end
      return t[AGE_BITS-1:0];
   endfunction

endpackage

@@ sv/rmf_queue.sv @@
// two-entry queue of back-end steps between front and back
// depends on rmf_pkg and assert_macros.svh
`include "assert_macros.svh"
module rmf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmf_pkg::job_type push_data,
   output logic             full,
   output logic             valid,
   input  logic             pop,
   output rmf_pkg::job_type pop_data
);
   import rmf_pkg::*;

   job_type    mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = mem_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   `RMF_ASSERT(a_count_range, count_ff <= 2'd2, "queue fill out of range")
   `RMF_ASSERT_IMPL(a_ptr_match, count_ff == 2'd0 || count_ff == 2'd2, wptr_ff == rptr_ff,
      "queue pointers disagree with fill")
   `RMF_ASSERT_IMPL(a_ptr_one, count_ff == 2'd1, wptr_ff != rptr_ff,
      "queue pointers disagree with single entry")
endmodule

@@ sv/rmf_front.sv @@
// front end: accepts items, tracks the sequence and queues back-end steps
// depends on rmf_pkg and assert_macros.svh
`include "assert_macros.svh"
module rmf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rmf_pkg::req_type               req_data,
   input  logic                           csr_we,
   input  logic [rmf_pkg::HALF_BITS-1:0]  csr_wdata,
   output logic                           push,
   output rmf_pkg::job_type               push_data,
   input  logic                           full
);
   import rmf_pkg::*;

   logic [HALF_BITS-1:0] cfg_half_ff;
   logic [HALF_BITS-1:0] half_ff, half_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 flush_ff, flush_in;
   logic [AGE_BITS-1:0]  d_ff, d_in;
   logic [CNT_BITS-1:0]  nm1_ff, nm1_in;

   logic                 accept;
   logic [HALF_BITS-1:0] h_sat, h_eff;
   logic [CNT_BITS-1:0]  n_new, nm1;
   logic [AGE_BITS-1:0]  two_h, dmax, dh, fl_dh;
   logic [AGE_BITS-1:0]  left_acc, left_fl;

   assign req_stall = flush_ff || full;
   assign accept    = req_valid && !req_stall;

   // half width for this item and window sizes
   always_comb begin
      h_sat = (cfg_half_ff > HALF_BITS'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : cfg_half_ff;
      h_eff = (count_ff == '0) ? h_sat : half_ff;
      n_new = (count_ff == '1) ? count_ff : count_ff + CNT_BITS'(1);
      nm1   = n_new - CNT_BITS'(1);
      two_h = {h_eff, 1'b0};
      dmax  = (AGE_BITS'(h_eff) < nm1) ? AGE_BITS'(h_eff) : nm1;
      dh    = dmax + AGE_BITS'(h_eff);
      fl_dh = d_ff + AGE_BITS'(half_ff);
      if (req_data.is_last) begin
         left_acc = (nm1 < dh) ? nm1 : dh;
      end else begin
         left_acc = (nm1 < two_h) ? nm1 : two_h;
      end
      left_fl = (nm1_ff < fl_dh) ? nm1_ff : fl_dh;
   end

   // step to queue: flushing steps first, else the accepted item
   always_comb begin
      push_data = '0;
      if (flush_ff) begin
         push               = !full;
         push_data.sample   = '0;
         push_data.wr       = 1'b0;
         push_data.emit     = 1'b1;
         push_data.left     = left_fl;
         push_data.fin      = (d_ff == '0);
      end else begin
         push               = accept;
         push_data.sample   = req_data.sample;
         push_data.wr       = 1'b1;
         push_data.emit     = req_data.is_last || (n_new > CNT_BITS'(h_eff));
         push_data.left     = left_acc;
         push_data.fin      = req_data.is_last && (dmax == '0);
      end
   end

   // sequence state
   always_comb begin
      half_in  = half_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      d_in     = d_ff;
      nm1_in   = nm1_ff;
      if (flush_ff) begin
         if (!full) begin
            d_in = d_ff - AGE_BITS'(1);
            if (d_ff == '0) begin
               flush_in = 1'b0;
            end
         end
      end else if (accept) begin
         half_in = h_eff;
         if (req_data.is_last) begin
            count_in = '0;
            nm1_in   = nm1;
            d_in     = dmax - AGE_BITS'(1);
            flush_in = (dmax != '0);
         end else begin
            count_in = n_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_half_ff <= HALF_BITS'(1);
         half_ff     <= '0;
         count_ff    <= '0;
         flush_ff    <= 1'b0;
         d_ff        <= '0;
         nm1_ff      <= '0;
      end else begin
         if (csr_we) begin
            cfg_half_ff <= csr_wdata;
         end
         half_ff  <= half_in;
         count_ff <= count_in;
         flush_ff <= flush_in;
         d_ff     <= d_in;
         nm1_ff   <= nm1_in;
      end
   end

   `RMF_ASSERT(a_half_cap, half_ff <= HALF_BITS'(MAX_HALF), "latched half width above limit")
   `RMF_ASSERT_IMPL(a_flush_idle, flush_ff, count_ff == '0, "flush with open sequence")
   `RMF_ASSERT_IMPL(a_flush_depth, flush_ff, d_ff < AGE_BITS'(half_ff), "flush step too deep")
endmodule

@@ sv/rmf_back.sv @@
// back end: window store and rank-count median search per emitting queued step
// depends on rmf_pkg and assert_macros.svh
`include "assert_macros.svh"
module rmf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rmf_pkg::job_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmf_pkg::rsp_type rsp_data
);
   import rmf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic signed [SAMPLE_BITS-1:0] store [DEPTH];

   logic [1:0]          state_ff, state_in;
   logic [AGE_BITS-1:0] wptr_ff, wptr_in;
   logic [AGE_BITS-1:0] m_ff;
   logic                fin_ff;
   logic [AGE_BITS-1:0] ci_ff, ci_in, sj_ff, sj_in;
   logic                iss_ff, iss_in;
   logic                p_valid_ff, p_first_ff, p_lastc_ff, p_lastall_ff;
   logic signed [SAMPLE_BITS-1:0] rd_c_ff, rd_s_ff;
   logic [CNT_BITS-1:0] lt_ff, le_ff, lt_new, le_new;
   logic signed [SAMPLE_BITS-1:0] v1_ff, v2_ff, v1_new, v2_new;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic [AGE_BITS-1:0] r1, r2, idx_c, idx_s, m_last;
   logic                iss_lastc, iss_lastall;

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // scan addresses and ranks of the two middle values
   always_comb begin
      m_last      = m_ff - AGE_BITS'(1);
      r1          = m_last >> 1;
      r2          = m_ff >> 1;
      idx_c       = age_to_idx(wptr_ff, ci_ff);
      idx_s       = age_to_idx(wptr_ff, sj_ff);
      iss_lastc   = (sj_ff == m_last);
      iss_lastall = iss_lastc && (ci_ff == m_last);
   end

   // rank counts of the candidate including this compare
   always_comb begin
      lt_new = (p_first_ff ? '0 : lt_ff) + CNT_BITS'(rd_s_ff < rd_c_ff);
      le_new = (p_first_ff ? '0 : le_ff) + CNT_BITS'(rd_s_ff <= rd_c_ff);
      v1_new = v1_ff;
      v2_new = v2_ff;
      if (p_valid_ff && p_lastc_ff) begin
         if (lt_new <= r1 && r1 < le_new) begin
            v1_new = rd_c_ff;
         end
         if (lt_new <= r2 && r2 < le_new) begin
            v2_new = rd_c_ff;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      wptr_in  = wptr_ff;
      ci_in    = ci_ff;
      sj_in    = sj_ff;
      iss_in   = iss_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_data.wr) begin
                  wptr_in = (wptr_ff == AGE_BITS'(DEPTH - 1)) ? '0 : wptr_ff + AGE_BITS'(1);
               end
               if (q_data.emit) begin
                  state_in = ST_SCAN;
                  ci_in    = '0;
                  sj_in    = '0;
                  iss_in   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (iss_ff) begin
               if (iss_lastc) begin
                  sj_in = '0;
                  if (iss_lastall) begin
                     iss_in = 1'b0;
                  end else begin
                     ci_in = ci_ff + AGE_BITS'(1);
                  end
               end else begin
                  sj_in = sj_ff + AGE_BITS'(1);
               end
            end
            if (p_valid_ff && p_lastall_ff) begin
               state_in = ST_WAIT;
               if (fin_ff) begin
                  wptr_in = '0;
               end
            end
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         iss_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wptr_ff    <= wptr_in;
         iss_ff     <= iss_in;
         p_valid_ff <= (state_ff == ST_SCAN) && iss_ff;
         if (state_ff == ST_SCAN && p_valid_ff && p_lastall_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // step payload, scan counters and datapath
   always_ff @(posedge clock) begin
      ci_ff <= ci_in;
      sj_ff <= sj_in;
      if (q_pop) begin
         m_ff   <= q_data.left + AGE_BITS'(1);
         fin_ff <= q_data.fin;
      end
      p_first_ff   <= (sj_ff == '0);
      p_lastc_ff   <= iss_lastc;
      p_lastall_ff <= iss_lastall;
      if (p_valid_ff) begin
         lt_ff <= lt_new;
         le_ff <= le_new;
      end
      v1_ff <= v1_new;
      v2_ff <= v2_new;
      if (state_ff == ST_SCAN && p_valid_ff && p_lastall_ff) begin
         rsp_ff.median_twice <= {v1_new[SAMPLE_BITS-1], v1_new}
                              + {v2_new[SAMPLE_BITS-1], v2_new};
         rsp_ff.final_result <= fin_ff;
      end
   end

   // window store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (q_pop && q_data.wr) begin
         store[wptr_ff] <= q_data.sample;
      end
      rd_c_ff <= store[idx_c];
      rd_s_ff <= store[idx_s];
   end

   `RMF_ASSERT(a_wptr_range, wptr_ff < AGE_BITS'(DEPTH), "store pointer out of range")
   `RMF_ASSERT_IMPL(a_pipe_scan, p_valid_ff, state_ff == ST_SCAN, "scan data outside scan")
   `RMF_ASSERT_IMPL(a_wait_valid, state_ff == ST_WAIT, rsp_valid_ff, "waiting without item")
endmodule

@@ sv/running_median_filter.sv @@
// running median filter: top level joining front end, step queue and back end
// depends on rmf_pkg, rmf_front, rmf_queue and rmf_back
// an emitting item's step passes the queue; the back end pops it only when idle, then scans
// every window pair over the store read ports and registers the result, one step at a time
// a last item queues one step per flushed position, each costing such a scan
// reset: synchronous, clears control state; half width returns to 1, sequence restarts
module running_median_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rmf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rmf_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [rmf_pkg::HALF_BITS-1:0]  csr_wdata
);
   import rmf_pkg::*;

   logic    push, full, q_valid, q_pop;
   job_type push_data, q_data;

   // item intake and step generation
   rmf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // decoupling queue
   rmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   // median search and result register
   rmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
